// File: design/integer_to_ascii_converter_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the integer to ASCII converter RTL
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_CONVERTER_UNIT_MACROS_SVH
`define INTEGER_TO_ASCII_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked on every rising edge out of reset
`define ITOA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itoa assertion failed");

// next-cycle implication
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itoa assertion failed");

`else

`define ITOA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/itoa_pkg.sv
// ---------------------------------------------------------------------------
// itoa_pkg
// Types, constants and the glyph function of the integer to ASCII converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int DIGITS_W   = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int REMAIN_W   = $clog2(NUM_DIGITS + 1);

    localparam logic [1:0] ACT_UDEC = 2'd0;
    localparam logic [1:0] ACT_SDEC = 2'd1;
    localparam logic [1:0] ACT_HEX  = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [DIGIT_W-1:0] DEC_BASE   = 4'd10;
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [VALUE_W-1:0] value;
    } itoa_in_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } itoa_out_t;

    // controls from the sequencer to the digit register
    typedef struct packed {
        logic clear;
        logic step;
        logic bit_in;
        logic adjust;
        logic shift_digit;
    } itoa_dab_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } itoa_state_t;

    function automatic logic [7:0] itoa_glyph(input logic [DIGIT_W-1:0] d);
        logic [7:0] code;
        if (d < DEC_BASE)
        begin
            code = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            code = CHAR_A + {4'd0, d - DEC_BASE};
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// File: design/itoa_dabble.sv
// ---------------------------------------------------------------------------
// itoa_dabble
// Digit register: takes one binary bit per cycle while step is raised (add-3
// correction for decimal, plain shift for hex) and hands digits out from the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_dabble (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire itoa_pkg::itoa_dab_ctl_t   ctl,
    output logic [itoa_pkg::DIGIT_W-1:0]   top_digit
);
    import itoa_pkg::*;

    logic [DIGITS_W-1:0] digits_reg;
    logic [DIGITS_W-1:0] digits_next;
    logic [DIGITS_W-1:0] adjusted;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (ctl.adjust && (digits_reg[i*DIGIT_W +: DIGIT_W] >= DABBLE_MIN))
            begin
                adjusted[i*DIGIT_W +: DIGIT_W] = digits_reg[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end
            else
            begin
                adjusted[i*DIGIT_W +: DIGIT_W] = digits_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        digits_next = digits_reg;
        if (ctl.clear)
        begin
            digits_next = '0;
        end
        else if (ctl.step)
        begin
            digits_next = {adjusted[DIGITS_W-2:0], ctl.bit_in};
        end
        else if (ctl.shift_digit)
        begin
            digits_next = {digits_reg[DIGITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg <= '0;
        end
        else
        begin
            digits_reg <= digits_next;
        end
    end

    assign top_digit = digits_reg[DIGITS_W-1 -: DIGIT_W];

endmodule

`default_nettype wire

// File: design/integer_to_ascii_converter_unit.sv
// ---------------------------------------------------------------------------
// integer_to_ascii_converter_unit
// Converts a 64-bit value to ASCII characters in decimal, signed decimal or
// upper-case hex, most significant digit first.
// ---------------------------------------------------------------------------
// Raise start with cmd while busy is low to hand in an item. The value is
// shifted into the digit register one bit per cycle, leading zero digits
// are then dropped at one per cycle (up to 19) until the zero scan ends, and
// the characters follow one per cycle, a minus first for a negative signed
// value. Each character is on result for one cycle with strobe high and last
// set on the final one; the receiver must take it then, there is no hold-off.
// An item passes through the conversion of every value bit, the 20 digit
// positions that are either dropped or emitted, the end of the zero scan and
// the output register. busy drops with the final character, so the next
// item can be taken at the edge that ends it.
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_ascii_converter_unit_macros.svh"

module integer_to_ascii_converter_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire itoa_pkg::itoa_in_t   cmd,
    output logic                      busy,
    output logic                      strobe,
    output itoa_pkg::itoa_out_t       result
);
    import itoa_pkg::*;

    itoa_state_t         state_reg,  state_next;
    logic [VALUE_W-1:0]  src_reg,    src_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [REMAIN_W-1:0] remain_reg, remain_next;
    logic                neg_reg,    neg_next;
    logic                hex_reg,    hex_next;
    logic                strobe_reg, strobe_next;
    itoa_out_t           result_reg, result_next;

    itoa_dab_ctl_t       dab_ctl;
    logic [DIGIT_W-1:0]  top_digit;
    logic                accept;
    logic                in_neg;

    itoa_dabble u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (dab_ctl),
        .top_digit (top_digit)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign in_neg = (cmd.action == ACT_SDEC) && cmd.value[VALUE_W-1];

    always_comb
    begin
        state_next  = state_reg;
        src_next    = src_reg;
        cnt_next    = cnt_reg;
        remain_next = remain_reg;
        neg_next    = neg_reg;
        hex_next    = hex_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        dab_ctl     = '0;
        dab_ctl.adjust = !hex_reg;
        dab_ctl.bit_in = src_reg[VALUE_W-1];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // take the magnitude up front
                    src_next      = in_neg ? (~cmd.value + VALUE_W'(1)) : cmd.value;
                    neg_next      = in_neg;
                    hex_next      = (cmd.action == ACT_HEX);
                    cnt_next      = CNT_W'(VALUE_W - 1);
                    dab_ctl.clear = 1'b1;
                    state_next    = ST_CONV;
                end
            end
            ST_CONV:
            begin
                dab_ctl.step = 1'b1;
                src_next     = {src_reg[VALUE_W-2:0], 1'b0};
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    remain_next = REMAIN_W'(NUM_DIGITS);
                    state_next  = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if ((top_digit == '0) && (remain_reg != REMAIN_W'(1)))
                begin
                    dab_ctl.shift_digit = 1'b1;
                    remain_next         = remain_reg - REMAIN_W'(1);
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                strobe_next           = 1'b1;
                result_next.char_code = CHAR_MINUS;
                result_next.last      = 1'b0;
                state_next            = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next           = 1'b1;
                result_next.char_code = itoa_glyph(top_digit);
                result_next.last      = (remain_reg == REMAIN_W'(1));
                dab_ctl.shift_digit   = 1'b1;
                remain_next           = remain_reg - REMAIN_W'(1);
                if (remain_reg == REMAIN_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            remain_reg <= '0;
            neg_reg    <= 1'b0;
            hex_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            remain_reg <= remain_next;
            neg_reg    <= neg_next;
            hex_reg    <= hex_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg    <= src_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    `ITOA_ASSERT_NOW(a_last_ends_item, clk, rst_n, strobe_reg && result_reg.last, state_reg == ST_IDLE)
    `ITOA_ASSERT_NOW(a_more_follows, clk, rst_n, strobe_reg && !result_reg.last, state_reg == ST_EMIT)
    `ITOA_ASSERT_NEXT(a_conv_flow, clk, rst_n, state_reg == ST_CONV, (state_reg == ST_CONV) || (state_reg == ST_SKIP))
    `ITOA_ASSERT_NOW(a_emit_has_digit, clk, rst_n, state_reg == ST_EMIT, remain_reg != '0)

endmodule

`default_nettype wire
